// ===== src/rmts_pkg.sv =====
// Shared types and constants for the rate monotonic tick scheduler.
// No dependencies; every other file imports this package.
package rmts_pkg;

    localparam int TASK_SLOTS = 4;
    localparam int CNT_W      = 16;
    localparam int TICK_W     = 32;
    localparam int TASK_W     = 2;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    typedef enum logic [2:0] {
        REG_PERIOD_0 = 3'd0,
        REG_PERIOD_1 = 3'd1,
        REG_PERIOD_2 = 3'd2,
        REG_PERIOD_3 = 3'd3,
        REG_BURST_0  = 3'd4,
        REG_BURST_1  = 3'd5,
        REG_BURST_2  = 3'd6,
        REG_BURST_3  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [TASK_SLOTS-1:0][CNT_W-1:0] period;
        logic [TASK_SLOTS-1:0][CNT_W-1:0] burst;
    } t_cfg;

    typedef struct packed {
        logic [TASK_W-1:0] running_task;
        logic              idle;
        logic              switched;
        logic [TICK_W-1:0] tick_time;
    } t_result;

endpackage

// ===== src/rmts_if.sv =====
// Valid/ready channel interfaces for tick input and schedule result.
// Depends on rmts_pkg for field widths.
interface rmts_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface rmts_sched_if
    import rmts_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TASK_W-1:0] running_task;
    logic              idle;
    logic              switched;
    logic [TICK_W-1:0] tick_time;

    modport source (output valid, output running_task, output idle, output switched,
                    output tick_time, input ready);
    modport sink   (input valid, input running_task, input idle, input switched,
                    input tick_time, output ready);
endinterface

// ===== src/rate_monotonic_tick_scheduler.sv =====
// Rate monotonic tick scheduler, four periodic tasks, one tick per transfer.
// Registered output: the result is valid in the cycle after the tick transfer.
// Throughput: one tick per clock while the result side is not stalled; the output register lets
// a tick be taken in the cycle its predecessor's result is taken.
// Reset (i_rst_n low, synchronous): no work, all tasks release on the first
// tick, tick time zero, last selection idle, periods 1, bursts 0.
module rate_monotonic_tick_scheduler
    import rmts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    rmts_tick_if.sink          i_tick,
    rmts_sched_if.source       o_sched,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg    cfg;
    t_result result;
    t_result r_result;
    logic    r_out_valid;
    logic    tick_xfer;

    rmts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_tick.ready = !r_out_valid || o_sched.ready;
    assign tick_xfer    = i_tick.valid && i_tick.ready;

    rmts_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_step    (tick_xfer),
        .i_restart (i_tick.restart),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_sched.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_xfer) begin
            r_result <= result;
        end
    end

    assign o_sched.valid        = r_out_valid;
    assign o_sched.running_task = r_result.running_task;
    assign o_sched.idle         = r_result.idle;
    assign o_sched.switched     = r_result.switched;
    assign o_sched.tick_time    = r_result.tick_time;

endmodule

// ===== src/rmts_cfg.sv =====
// APB-style configuration registers: task periods and bursts.
// Depends on rmts_pkg.
module rmts_cfg
    import rmts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    t_reg_idx   idx;
    logic       wr_en;
    logic [CNT_W-1:0] rd_val;
    logic [CNT_W-1:0] wr_val;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_val = pwdata[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_cfg.period[i] <= CNT_W'(1);
                r_cfg.burst[i]  <= '0;
            end
        end else if (wr_en) begin
            unique case (idx)
                REG_PERIOD_0: r_cfg.period[0] <= wr_val;
                REG_PERIOD_1: r_cfg.period[1] <= wr_val;
                REG_PERIOD_2: r_cfg.period[2] <= wr_val;
                REG_PERIOD_3: r_cfg.period[3] <= wr_val;
                REG_BURST_0:  r_cfg.burst[0]  <= wr_val;
                REG_BURST_1:  r_cfg.burst[1]  <= wr_val;
                REG_BURST_2:  r_cfg.burst[2]  <= wr_val;
                REG_BURST_3:  r_cfg.burst[3]  <= wr_val;
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PERIOD_0: rd_val = r_cfg.period[0];
            REG_PERIOD_1: rd_val = r_cfg.period[1];
            REG_PERIOD_2: rd_val = r_cfg.period[2];
            REG_PERIOD_3: rd_val = r_cfg.period[3];
            REG_BURST_0:  rd_val = r_cfg.burst[0];
            REG_BURST_1:  rd_val = r_cfg.burst[1];
            REG_BURST_2:  rd_val = r_cfg.burst[2];
            REG_BURST_3:  rd_val = r_cfg.burst[3];
            default:      rd_val = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-CNT_W){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

// ===== src/rmts_core.sv =====
// Scheduler state and one-tick update: release, priority pick, work decrement.
// Depends on rmts_pkg.
module rmts_core
    import rmts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step,
    input  logic    i_restart,
    output t_result o_result
);

    logic [TASK_SLOTS-1:0][CNT_W-1:0] r_work;
    logic [TASK_SLOTS-1:0][CNT_W-1:0] r_cdown;
    logic [TASK_SLOTS-1:0][CNT_W-1:0] n_work;
    logic [TASK_SLOTS-1:0][CNT_W-1:0] n_cdown;
    logic [TASK_SLOTS-1:0][CNT_W-1:0] eff_p;
    logic [TASK_SLOTS-1:0][CNT_W-1:0] rel_work;
    logic                 r_last_idle;
    logic [TASK_W-1:0]    r_last_task;
    logic [TICK_W-1:0]    r_tick;
    logic [TICK_W-1:0]    now;
    logic                 found;
    logic [TASK_W-1:0]    sel;
    logic [CNT_W-1:0]     best_p;

    assign now = i_restart ? '0 : r_tick;

    always_comb begin
        found  = 1'b0;
        sel    = '0;
        best_p = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            // a period of zero behaves as one
            eff_p[i] = (i_cfg.period[i] == '0) ? CNT_W'(1) : i_cfg.period[i];
            if (i_restart || r_cdown[i] == '0) begin
                rel_work[i] = i_cfg.burst[i];
                n_cdown[i]  = eff_p[i] - CNT_W'(1);
            end else begin
                rel_work[i] = r_work[i];
                n_cdown[i]  = r_cdown[i] - CNT_W'(1);
            end
        end
        // shortest period wins, strict compare keeps the lower index on ties
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (rel_work[i] != '0 && (!found || eff_p[i] < best_p)) begin
                found  = 1'b1;
                sel    = TASK_W'(i);
                best_p = eff_p[i];
            end
        end
        for (int i = 0; i < TASK_SLOTS; i++) begin
            n_work[i] = rel_work[i] - CNT_W'(found && sel == TASK_W'(i));
        end
    end

    always_comb begin
        o_result.running_task = sel;
        o_result.idle         = !found;
        o_result.switched     = (found == r_last_idle) || (found && sel != r_last_task);
        o_result.tick_time    = now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work      <= '0;
            r_cdown     <= '0;
            r_last_idle <= 1'b1;
            r_last_task <= '0;
            r_tick      <= '0;
        end else if (i_step) begin
            r_work      <= n_work;
            r_cdown     <= n_cdown;
            r_last_idle <= !found;
            r_last_task <= sel;
            r_tick      <= now + TICK_W'(1);
        end
    end

endmodule

// ===== tb/rate_monotonic_tick_scheduler_tb.sv =====
// Self-checking testbench for the rate monotonic tick scheduler.
// Depends on rmts_pkg, rmts_if and the rate_monotonic_tick_scheduler RTL.
module rate_monotonic_tick_scheduler_tb
    import rmts_pkg::*;
;

    localparam logic [2:0] SEL_IDLE    = 3'd4;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         HOLD_CYCLES = 300;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    rmts_tick_if  tick_ch ();
    rmts_sched_if sched_ch ();

    rate_monotonic_tick_scheduler i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_ch),
        .o_sched (sched_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // scheduler state as predicted
    logic [CNT_W-1:0]  period_cfg [TASK_SLOTS];
    logic [CNT_W-1:0]  burst_cfg  [TASK_SLOTS];
    logic [CNT_W-1:0]  work_left  [TASK_SLOTS];
    logic [CNT_W-1:0]  release_in [TASK_SLOTS];
    logic [2:0]        prev_sel;
    logic [TICK_W-1:0] tick_count;

    t_result expected_sched [$];
    int      errors;
    bit      idle_en;
    bit      hold_req;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [CNT_W-1:0] eff_period(int slot);
        return (period_cfg[slot] == '0) ? CNT_W'(1) : period_cfg[slot];
    endfunction

    function automatic void reset_schedule();
        for (int i = 0; i < TASK_SLOTS; i++) begin
            period_cfg[i] = CNT_W'(1);
            burst_cfg[i]  = '0;
            work_left[i]  = '0;
            release_in[i] = '0;
        end
        prev_sel   = SEL_IDLE;
        tick_count = '0;
    endfunction

    function automatic t_result schedule_tick(logic restart);
        t_result           res;
        logic [2:0]        sel;
        logic [TICK_W-1:0] now;
        sel = SEL_IDLE;
        if (restart)
            tick_count = '0;
        now = tick_count;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (restart || release_in[i] == '0) begin
                work_left[i]  = burst_cfg[i];
                release_in[i] = eff_period(i) - CNT_W'(1);
            end else begin
                release_in[i] = release_in[i] - CNT_W'(1);
            end
        end
        // shortest period wins, strict compare keeps the lower index on ties
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (work_left[i] != '0 &&
                (sel == SEL_IDLE || eff_period(i) < eff_period(int'(sel)))) begin
                sel = 3'(i);
            end
        end
        if (sel != SEL_IDLE)
            work_left[sel[1:0]] = work_left[sel[1:0]] - CNT_W'(1);
        res.running_task = (sel == SEL_IDLE) ? '0 : sel[1:0];
        res.idle         = (sel == SEL_IDLE);
        res.switched     = (sel != prev_sel);
        res.tick_time    = now;
        prev_sel   = sel;
        tick_count = now + TICK_W'(1);
        return res;
    endfunction

    function automatic void check_schedule();
        t_result want;
        if (expected_sched.size() == 0) begin
            $error("result with no tick outstanding: task %0d idle %0d",
                   sched_ch.running_task, sched_ch.idle);
            errors++;
            return;
        end
        want = expected_sched.pop_front();
        if (sched_ch.running_task !== want.running_task) begin
            $error("running_task: expected %0d, got %0d",
                   want.running_task, sched_ch.running_task);
            errors++;
        end
        if (sched_ch.idle !== want.idle) begin
            $error("idle: expected %0d, got %0d", want.idle, sched_ch.idle);
            errors++;
        end
        if (sched_ch.switched !== want.switched) begin
            $error("switched: expected %0d, got %0d", want.switched, sched_ch.switched);
            errors++;
        end
        if (sched_ch.tick_time !== want.tick_time) begin
            $error("tick_time: expected %0d, got %0d", want.tick_time, sched_ch.tick_time);
            errors++;
        end
    endfunction

    // result side: random stalls plus one long hold on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        sched_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && sched_ch.valid && sched_ch.ready)
                check_schedule();
            if (hold_left > 0) begin
                hold_left--;
                sched_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                sched_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                sched_ch.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                sched_ch.ready <= 1'b0;
            end else begin
                sched_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || psel || (tick_ch.valid && tick_ch.ready) ||
                (sched_ch.valid && sched_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_tick(logic restart);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= restart;
        do @(posedge clk); while (!tick_ch.ready);
        expected_sched.push_back(schedule_tick(restart));
    endtask

    task automatic finish_phase();
        tick_ch.valid <= 1'b0;
        while (expected_sched.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // setup, access, then a quiet bus; the register takes the data at the access edge
    task automatic write_reg(t_reg_idx idx, logic [CNT_W-1:0] value);
        int slot = int'(idx) % TASK_SLOTS;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx < REG_BURST_0)
            period_cfg[slot] = value;
        else
            burst_cfg[slot] = value;
        @(posedge clk);
    endtask

    task automatic read_reg(t_reg_idx idx);
        int               slot = int'(idx) % TASK_SLOTS;
        logic [CNT_W-1:0] want;
        want = (idx < REG_BURST_0) ? period_cfg[slot] : burst_cfg[slot];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== PDATA_W'(want)) begin
            $error("%s: expected %h, got %h", idx.name(), PDATA_W'(want), prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_task(int slot, logic [CNT_W-1:0] period, logic [CNT_W-1:0] burst);
        write_reg(t_reg_idx'(int'(REG_PERIOD_0) + slot), period);
        write_reg(t_reg_idx'(int'(REG_BURST_0) + slot), burst);
    endtask

    function automatic logic [CNT_W-1:0] rand_period();
        int pick = $urandom_range(0, 15);
        if (pick == 0)
            return CNT_W'($urandom);
        if (pick == 1)
            return '0;
        return CNT_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [CNT_W-1:0] rand_burst();
        int pick = $urandom_range(0, 15);
        if (pick < 2)
            return '0;
        if (pick == 2)
            return CNT_W'($urandom);
        return CNT_W'($urandom_range(1, 6));
    endfunction

    task automatic randomize_tasks();
        for (int s = 0; s < TASK_SLOTS; s++)
            set_task(s, rand_period(), rand_burst());
    endtask

    task automatic test_reset_values();
        for (int r = int'(REG_PERIOD_0); r <= int'(REG_BURST_3); r++)
            read_reg(t_reg_idx'(r));
        repeat (3) send_tick(1'b0);
        finish_phase();
    endtask

    task automatic test_register_access();
        for (int r = int'(REG_PERIOD_0); r <= int'(REG_BURST_3); r++)
            write_reg(t_reg_idx'(r), (r % 2 == 0) ? 16'hFFFF : 16'h0000);
        for (int r = int'(REG_PERIOD_0); r <= int'(REG_BURST_3); r++)
            read_reg(t_reg_idx'(r));
        for (int r = int'(REG_PERIOD_0); r <= int'(REG_BURST_3); r++)
            write_reg(t_reg_idx'(r), (r % 2 == 0) ? 16'h0000 : 16'hFFFF);
        for (int r = int'(REG_PERIOD_0); r <= int'(REG_BURST_3); r++)
            read_reg(t_reg_idx'(r));
        for (int r = int'(REG_PERIOD_0); r <= int'(REG_BURST_3); r++)
            write_reg(t_reg_idx'(r), CNT_W'($urandom));
        for (int r = int'(REG_PERIOD_0); r <= int'(REG_BURST_3); r++)
            read_reg(t_reg_idx'(r));
    endtask

    task automatic test_directed();
        set_task(0, 16'd4, 16'd2);
        set_task(1, 16'd0, 16'd0);          // zero period acts as one, zero burst disables
        set_task(2, 16'd4, 16'd3);          // same period as task 0, loses the tie
        set_task(3, 16'hFFFF, 16'hFFFF);
        send_tick(1'b1);
        repeat (9) send_tick(1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        finish_phase();
        // changed without restart: zero period releases every tick and drops leftover work
        set_task(1, 16'd0, 16'd3);
        set_task(0, 16'd1, 16'd2);
        repeat (6) send_tick(1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        finish_phase();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                for (int s = 0; s < TASK_SLOTS; s++)
                    set_task(s, 16'd1, 16'd1);
            end else if (ph == 1) begin
                for (int s = 0; s < TASK_SLOTS; s++)
                    set_task(s, 16'hFFFF, 16'hFFFF);
            end else begin
                randomize_tasks();
            end
            repeat (180) send_tick($urandom_range(0, 39) == 0);
            finish_phase();
        end
    endtask

    task automatic test_backpressure();
        randomize_tasks();
        hold_req = 1'b1;
        repeat (40) send_tick($urandom_range(0, 19) == 0);
        finish_phase();
    endtask

    task automatic test_steady_stream();
        idle_en = 1'b0;
        randomize_tasks();
        repeat (150) send_tick($urandom_range(0, 29) == 0);
        finish_phase();
    endtask

    initial begin
        errors   = 0;
        idle_en  = 1'b1;
        hold_req = 1'b0;
        reset_schedule();
        rst_n           <= 1'b0;
        tick_ch.valid   <= 1'b0;
        tick_ch.restart <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_register_access();
        test_directed();
        test_random();
        test_backpressure();
        test_steady_stream();

        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rmts_pkg.sv
src/rmts_if.sv
src/rmts_cfg.sv
src/rmts_core.sv
src/rate_monotonic_tick_scheduler.sv
tb/rate_monotonic_tick_scheduler_tb.sv
